/* sv/md5_pkg.sv */
//------------------------------------------------------------------------------
// md5_pkg
// shared constants, types and round tables for the md5 digest block
//------------------------------------------------------------------------------
`default_nettype none
package md5_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ChunkWords = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned LenW    = 61;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // one queued word for the compression side; fin marks the chunk that ends
  // the message
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } qword_t;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
        4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
        4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word index used by a round
  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] g;
    begin
      case (r[5:4])
        2'd0:    g = r[3:0];
        2'd1:    g = 4'(({2'b0, r[3:0]} * 6'd5) + 6'd1);
        2'd2:    g = 4'(({2'b0, r[3:0]} * 6'd3) + 6'd5);
        default: g = 4'({2'b0, r[3:0]} * 6'd7);
      endcase
      return g;
    end
  endfunction

endpackage
`default_nettype wire

/* sv/md5_message_digest_top.sv */
//------------------------------------------------------------------------------
// md5_message_digest_top
// streaming md5 hash of a word-wide message
//------------------------------------------------------------------------------
// usage: drive in_data_word, in_valid_bytes, in_last with start; a transaction
// is taken on a clock edge with start high and busy low. words are little
// endian, only the last word may be partial, an empty message is one word
// with zero bytes and last set.
// a front end counts the length, expands the 0x80 pad, zero fill and 64-bit
// bit length into a four-entry queue. the core drains the queue into a
// 16-word chunk ram (one word a cycle while the queue is not empty) and then
// runs 64 rounds, one a cycle, plus a final step to fold in the chain values.
// throughput is set by the single round unit, which takes no words while a
// chunk is in its rounds. after the last word, out_valid pulses for one cycle
// with the digest once the one or two final chunks have been folded in.
// busy is high while the queue is full or padding is being generated.
// reset (synchronous, rst_n low) returns the chain values to their initial
// values and empties the queue; the chunk ram needs no clearing.
// the receiver cannot stall: out_valid is a one-cycle strobe.
//------------------------------------------------------------------------------
`default_nettype none
module md5_message_digest_top #(
  parameter int unsigned QDepth = md5_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [31:0]      out_digest_a,
  output logic [31:0]      out_digest_b,
  output logic [31:0]      out_digest_c,
  output logic [31:0]      out_digest_d
);

  logic            q_push, q_full, q_pop, q_empty;
  md5_pkg::qword_t q_wdata, q_rdata;

  md5_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .data_word   (in_data_word),
    .valid_bytes (in_valid_bytes),
    .last        (in_last),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  md5_queue #(.Depth(QDepth)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  md5_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .done     (out_valid),
    .digest_a (out_digest_a),
    .digest_b (out_digest_b),
    .digest_c (out_digest_c),
    .digest_d (out_digest_d)
  );

endmodule
`default_nettype wire

/* sv/md5_ram.sv */
//------------------------------------------------------------------------------
// md5_ram
// generic single-port-write, single-port-read ram with registered read
//------------------------------------------------------------------------------
`default_nettype none
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/md5_front.sv */
//------------------------------------------------------------------------------
// md5_front
// takes message words, counts length, expands padding into queued words
//------------------------------------------------------------------------------
`default_nettype none
module md5_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [31:0]                 data_word,
  input  wire logic [2:0]                  valid_bytes,
  input  wire logic                        last,
  output logic                             q_push,
  output md5_pkg::qword_t                  q_data,
  input  wire logic                        q_full
);

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_LENL = 2'd2;
  localparam logic [1:0] ST_LENH = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic [md5_pkg::LenW-1:0] len_r, len_nxt;
  logic [31:0]             pend_r, pend_nxt;   // pad word still to send
  logic                    pend_v_r, pend_v_nxt;
  logic [2:0]              nb;
  logic [31:0]             keep, padw;
  logic [63:0]             bits;
  logic                    acc;

  assign busy = (state_r != ST_IN) || q_full;
  assign acc  = start && !busy;
  assign nb   = (!last || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  assign bits = {len_r, 3'b000};

  always_comb begin
    keep = 32'hffffffff;
    padw = 32'h0;
    case (nb)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'h000000ff;
      3'd2: keep = 32'h0000ffff;
      3'd3: keep = 32'h00ffffff;
      default: keep = 32'hffffffff;
    endcase
    case (nb)
      3'd0: padw = {24'h0, md5_pkg::PadByte};
      3'd1: padw = (data_word & keep) | {16'h0, md5_pkg::PadByte, 8'h0};
      3'd2: padw = (data_word & keep) | {8'h0, md5_pkg::PadByte, 16'h0};
      3'd3: padw = (data_word & keep) | {md5_pkg::PadByte, 24'h0};
      default: padw = data_word;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    q_push     = 1'b0;
    q_data     = '{word: 32'h0, fin: 1'b0};
    unique case (state_r)
      ST_IN: begin
        if (acc) begin
          len_nxt = len_r + md5_pkg::LenW'(nb);
          if (nb == 3'd4) begin
            q_push = 1'b1;
            q_data = '{word: data_word, fin: 1'b0};
            pos_nxt = pos_r + 4'd1;
            if (last) begin
              pend_nxt   = {24'h0, md5_pkg::PadByte};
              pend_v_nxt = 1'b1;
              state_nxt  = ST_PAD;
            end
          end else begin
            pend_nxt   = padw;
            pend_v_nxt = 1'b1;
            state_nxt  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data = '{word: pend_v_r ? pend_r : 32'h0, fin: 1'b0};
          pend_v_nxt = 1'b0;
          pos_nxt = pos_r + 4'd1;
          if (pos_r == 4'd13) begin
            state_nxt = ST_LENL;
          end
        end
      end
      ST_LENL: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data = '{word: bits[31:0], fin: 1'b0};
          pos_nxt = pos_r + 4'd1;
          state_nxt = ST_LENH;
        end
      end
      ST_LENH: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data = '{word: bits[63:32], fin: 1'b1};
          pos_nxt = 4'd0;
          len_nxt = '0;
          state_nxt = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IN;
      pos_r    <= 4'd0;
      len_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      pend_v_r <= pend_v_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule
`default_nettype wire

/* sv/md5_queue.sv */
//------------------------------------------------------------------------------
// md5_queue
// small fifo between the word front end and the compression core
//------------------------------------------------------------------------------
`default_nettype none
module md5_queue #(
  parameter int unsigned Depth = md5_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire md5_pkg::qword_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output md5_pkg::qword_t      rdata,
  output logic                 empty
);

  localparam int unsigned AW = $clog2(Depth);

  md5_pkg::qword_t   slot_r [Depth];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;

  assign full  = (cnt_r == (AW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* sv/md5_core.sv */
//------------------------------------------------------------------------------
// md5_core
// fills the chunk ram from the queue, runs 64 rounds, one per cycle, and adds the result into the chain values
//------------------------------------------------------------------------------
`default_nettype none
module md5_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire md5_pkg::qword_t q_data,
  output logic                 q_pop,
  output logic                 done,
  output logic [31:0]          digest_a,
  output logic [31:0]          digest_b,
  output logic [31:0]          digest_c,
  output logic [31:0]          digest_d
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_RND  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0]  state_r;
  logic [3:0]  wpos_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [31:0] ha_r, hb_r, hc_r, hd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] mw, f, t, rot;
  logic [5:0]  rnd_rd;
  logic [4:0]  s;
  logic [63:0] dbl;

  // the ram read runs one round ahead of the datapath
  assign rnd_rd = (state_r == ST_RND) ? rnd_r + 6'd1 : 6'd0;

  md5_ram #(.Width(32), .Depth(md5_pkg::ChunkWords)) u_ram (
    .clk   (clk),
    .we    (q_pop),
    .waddr (wpos_r),
    .wdata (q_data.word),
    .raddr (md5_pkg::msg_idx(rnd_rd)),
    .rdata (mw)
  );

  assign q_pop = (state_r == ST_FILL) && !q_empty;
  assign digest_a = ha_r;
  assign digest_b = hb_r;
  assign digest_c = hc_r;
  assign digest_d = hd_r;

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t   = f + a_r + md5_pkg::sine_k(rnd_r) + mw;
    s   = md5_pkg::rot_s(rnd_r);
    dbl = {t, t} << s;
    rot = dbl[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      wpos_r  <= 4'd0;
      rnd_r   <= 6'd0;
      fin_r   <= 1'b0;
      done    <= 1'b0;
      ha_r <= md5_pkg::InitA; hb_r <= md5_pkg::InitB;
      hc_r <= md5_pkg::InitC; hd_r <= md5_pkg::InitD;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        ST_FILL: begin
          if (q_pop) begin
            wpos_r <= wpos_r + 4'd1;
            if (wpos_r == 4'd15) begin
              fin_r   <= q_data.fin;
              state_r <= ST_RND;
              rnd_r   <= 6'd0;
            end
          end
          if (done) begin
            ha_r <= md5_pkg::InitA; hb_r <= md5_pkg::InitB;
            hc_r <= md5_pkg::InitC; hd_r <= md5_pkg::InitD;
          end
        end
        ST_RND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          ha_r <= ha_r + a_r; hb_r <= hb_r + b_r;
          hc_r <= hc_r + c_r; hd_r <= hd_r + d_r;
          done    <= fin_r;
          state_r <= ST_FILL;
        end
        default: state_r <= ST_FILL;
      endcase
    end
    if (state_r == ST_FILL) begin
      a_r <= ha_r; b_r <= hb_r; c_r <= hc_r; d_r <= hd_r;
      if (done) begin
        a_r <= md5_pkg::InitA; b_r <= md5_pkg::InitB;
        c_r <= md5_pkg::InitC; d_r <= md5_pkg::InitD;
      end
    end else if (state_r == ST_RND) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end
  end

endmodule
`default_nettype wire
